// ----- hw/rtl/md_block_padder_macros.svh -----
// assertion macros for the md_block_padder rtl
// expects clk and rst_n in the scope of each use
`ifndef MD_BLOCK_PADDER_MACROS_SVH
`define MD_BLOCK_PADDER_MACROS_SVH

// same-cycle implication
`define MDBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mdbp_pkg.sv -----
// shared types and constants for the md_block_padder block
// no dependencies
`default_nettype none

package mdbp_pkg;

  localparam int BLOCK_BYTES     = 64;
  localparam int DATA_W          = 8;
  localparam int LANES           = 4;
  localparam int LANE_W          = 2;
  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / LANES;
  localparam int WORD_IDX_W      = 4;
  localparam int FILL_W          = 6;
  localparam int COUNT_W         = 61;
  localparam int LEN_AT          = BLOCK_BYTES - 8;
  localparam int WORD_W          = DATA_W * LANES;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [DATA_W-1:0]     PAD_MARK  = 8'h80;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS_PER_BLOCK - 1);
  localparam logic [FILL_W-1:0]     LAST_BYTE = FILL_W'(BLOCK_BYTES - 1);

  // kind of block being emitted
  typedef enum logic [1:0] {
    BLK_DATA,  // full block of message bytes
    BLK_PAD,   // message tail, 0x80, zero fill and length
    BLK_MARK,  // message tail, 0x80, zero fill, no room for length
    BLK_LEN    // zero fill and length only
  } blk_t;

  typedef struct packed {
    logic                  wr;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  load;
    logic [WORD_IDX_W-1:0] word_idx;
    blk_t                  blk;
    logic                  last;
    logic                  finish;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mdbp_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module mdbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mdbp_dp.sv -----
// datapath: byte lanes, fill and length counters, padding mux, output register
// depends on mdbp_pkg and mdbp_ram
`default_nettype none

module mdbp_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [mdbp_pkg::DATA_W-1:0]      in_byte,
  input  wire logic                             cfg_wr,
  input  wire logic                             cfg_bit,
  input  wire mdbp_pkg::cmd_t                   cmd,
  output mdbp_pkg::sts_t                        sts,
  output logic [mdbp_pkg::WORD_W-1:0]           word,
  output logic [mdbp_pkg::WORD_IDX_W-1:0]       word_idx,
  output logic                                  final_blk,
  output logic                                  last
);

  logic [mdbp_pkg::FILL_W-1:0]     fill_r;
  logic [mdbp_pkg::COUNT_W-1:0]    cnt_r;
  logic                            len_be_r;
  logic [mdbp_pkg::WORD_W-1:0]     word_r;
  logic [mdbp_pkg::WORD_IDX_W-1:0] idx_r;
  logic                            final_r;
  logic                            last_r;

  logic [mdbp_pkg::DATA_W-1:0]     lane_q [mdbp_pkg::LANES];
  logic [mdbp_pkg::WORD_W-1:0]     word_nxt;
  logic [mdbp_pkg::FILL_W:0]       lim;
  logic                            mark_en;
  logic                            len_en;
  logic [63:0]                     bits;

  for (genvar l = 0; l < mdbp_pkg::LANES; l++) begin : g_lane
    mdbp_ram #(
      .WIDTH(mdbp_pkg::DATA_W),
      .DEPTH(mdbp_pkg::WORDS_PER_BLOCK)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.wr && (fill_r[mdbp_pkg::LANE_W-1:0] == mdbp_pkg::LANE_W'(l))),
      .waddr(fill_r[mdbp_pkg::FILL_W-1:mdbp_pkg::LANE_W]),
      .wdata(in_byte),
      .raddr(cmd.rd_addr),
      .rdata(lane_q[l])
    );
  end

  always_comb begin
    case (cmd.blk)
      mdbp_pkg::BLK_DATA: begin
        lim = (mdbp_pkg::FILL_W+1)'(mdbp_pkg::BLOCK_BYTES);
        mark_en = 1'b0;
        len_en = 1'b0;
      end
      mdbp_pkg::BLK_PAD: begin
        lim = {1'b0, fill_r};
        mark_en = 1'b1;
        len_en = 1'b1;
      end
      mdbp_pkg::BLK_MARK: begin
        lim = {1'b0, fill_r};
        mark_en = 1'b1;
        len_en = 1'b0;
      end
      default: begin
        lim = '0;
        mark_en = 1'b0;
        len_en = 1'b1;
      end
    endcase
  end

  assign bits = {cnt_r, 3'b000};

  always_comb begin
    logic [mdbp_pkg::FILL_W:0] pos;
    logic [2:0]                sel;
    for (int l = 0; l < mdbp_pkg::LANES; l++) begin
      pos = {1'b0, cmd.word_idx, mdbp_pkg::LANE_W'(l)};
      sel = {cmd.word_idx[0], mdbp_pkg::LANE_W'(l)};
      if (len_be_r) begin
        sel = ~sel;
      end
      if (pos < lim) begin
        word_nxt[l*mdbp_pkg::DATA_W +: mdbp_pkg::DATA_W] = lane_q[l];
      end else if (mark_en && (pos == lim)) begin
        word_nxt[l*mdbp_pkg::DATA_W +: mdbp_pkg::DATA_W] = mdbp_pkg::PAD_MARK;
      end else if (len_en && (pos >= (mdbp_pkg::FILL_W+1)'(mdbp_pkg::LEN_AT))) begin
        word_nxt[l*mdbp_pkg::DATA_W +: mdbp_pkg::DATA_W] = bits[{sel, 3'b000} +: 8];
      end else begin
        word_nxt[l*mdbp_pkg::DATA_W +: mdbp_pkg::DATA_W] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cnt_r    <= '0;
      len_be_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        len_be_r <= cfg_bit;
      end
      if (cmd.finish) begin
        fill_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.wr) begin
        fill_r <= fill_r + 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r  <= word_nxt;
      idx_r   <= cmd.word_idx;
      final_r <= len_en;
      last_r  <= cmd.last;
    end
  end

  assign sts.fill  = fill_r;
  assign word      = word_r;
  assign word_idx  = idx_r;
  assign final_blk = final_r;
  assign last      = last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mdbp_ctrl.sv -----
// controller: input handshake, block sequencing and word stepping
// depends on mdbp_pkg and md_block_padder_macros.svh
`default_nettype none
`include "md_block_padder_macros.svh"

module mdbp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic           in_byte_valid,
  input  wire logic           in_eom,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire mdbp_pkg::sts_t sts,
  output mdbp_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD, S_SHOW} state_t;

  state_t                          st_r;
  logic [mdbp_pkg::WORD_IDX_W-1:0] w_r;
  mdbp_pkg::blk_t                  blk_r;
  logic                            eom_pend_r;

  logic                            accept;
  logic                            out_xfer;
  logic                            item_done;
  logic [mdbp_pkg::FILL_W:0]       fill_after;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_SHOW);
  assign accept     = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;
  assign fill_after = {1'b0, sts.fill} + (mdbp_pkg::FILL_W+1)'(in_byte_valid);

  // block after which the message is finished
  assign item_done = (blk_r == mdbp_pkg::BLK_PAD) || (blk_r == mdbp_pkg::BLK_LEN);

  assign cmd.wr       = accept && in_byte_valid;
  assign cmd.rd_addr  = (st_r == S_SHOW) ? w_r + 1'b1 : w_r;
  assign cmd.load     = (st_r == S_LOAD);
  assign cmd.word_idx = w_r;
  assign cmd.blk      = blk_r;
  assign cmd.last     = (w_r == mdbp_pkg::LAST_WORD) &&
                        (item_done || ((blk_r == mdbp_pkg::BLK_DATA) && !eom_pend_r));
  assign cmd.finish   = out_xfer && (w_r == mdbp_pkg::LAST_WORD) && item_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      w_r        <= '0;
      blk_r      <= mdbp_pkg::BLK_DATA;
      eom_pend_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          w_r <= '0;
          if (accept) begin
            if (in_byte_valid && (sts.fill == mdbp_pkg::LAST_BYTE)) begin
              blk_r      <= mdbp_pkg::BLK_DATA;
              eom_pend_r <= in_eom;
              st_r       <= S_READ;
            end else if (in_eom) begin
              blk_r      <= (fill_after >= (mdbp_pkg::FILL_W+1)'(mdbp_pkg::LEN_AT)) ?
                            mdbp_pkg::BLK_MARK : mdbp_pkg::BLK_PAD;
              eom_pend_r <= 1'b0;
              st_r       <= S_READ;
            end
          end
        end
        S_READ: begin
          st_r <= S_LOAD;
        end
        S_LOAD: begin
          st_r <= S_SHOW;
        end
        S_SHOW: begin
          if (out_tready) begin
            w_r <= w_r + 1'b1;
            if (w_r != mdbp_pkg::LAST_WORD) begin
              st_r <= S_LOAD;
            end else begin
              case (blk_r)
                mdbp_pkg::BLK_DATA: begin
                  if (eom_pend_r) begin
                    blk_r      <= mdbp_pkg::BLK_PAD;
                    eom_pend_r <= 1'b0;
                    st_r       <= S_LOAD;
                  end else begin
                    st_r <= S_IDLE;
                  end
                end
                mdbp_pkg::BLK_MARK: begin
                  blk_r <= mdbp_pkg::BLK_LEN;
                  st_r  <= S_LOAD;
                end
                default: begin
                  st_r <= S_IDLE;
                end
              endcase
            end
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  `MDBP_ASSERT_NEXT(a_word_step, out_xfer && (w_r != mdbp_pkg::LAST_WORD), (st_r == S_LOAD) && (w_r == mdbp_pkg::WORD_IDX_W'($past(w_r) + 1'b1)), "word index did not advance after transfer")
  `MDBP_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, (st_r == S_SHOW) && $stable(w_r) && $stable(blk_r), "word state changed while stalled")
  `MDBP_ASSERT_NEXT(a_eom_emits, accept && in_eom, st_r == S_READ, "end of message did not start a block")
  `MDBP_ASSERT_NOW(a_no_pend_late, (blk_r != mdbp_pkg::BLK_DATA) && (st_r != S_IDLE), !eom_pend_r, "pending end of message outside a data block")

endmodule

`default_nettype wire

// ----- hw/rtl/md_block_padder.sv -----
// md_block_padder: top level, 64-byte block gathering and message padding
// depends on mdbp_pkg, mdbp_ctrl, mdbp_dp and mdbp_ram
//
// usage:
// in channel carries one message byte per transfer: in_tdata is the byte,
// in_tuser[0] says the byte is present, in_tlast ends the message after it.
// out channel carries 16 words per 64-byte block, byte 0 of each word in bits 7:0.
// out_tuser[0] marks words of the block holding the bit length, out_tlast the
// final word caused by one input transfer. cfg_data[0] picks length byte
// order (0 little endian, 1 big endian); write it only while the block is idle.
// in_tready stays high after an input transfer that emits nothing. one that emits
// blocks raises out_tvalid with its first word after a ram read state and an output
// register load state; after that, each word taken while out_tready is high starts the
// word loop (ram read, then output register load) for the next one. in_tready stays
// low until the last word leaves. a transfer may cause up to two blocks (32 words).
// a stalled receiver holds the current word in the output register unchanged.
// reset clears the fill and length counters and selects little endian.
`default_nettype none

module md_block_padder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic [0:0]  in_tuser,   // byte_valid
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // block_word, word_index, zero fill
  output logic [0:0]       out_tuser,  // final_block
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data    // length_big_endian
);

  mdbp_pkg::cmd_t                  cmd;
  mdbp_pkg::sts_t                  sts;
  logic [mdbp_pkg::WORD_W-1:0]     word;
  logic [mdbp_pkg::WORD_IDX_W-1:0] word_idx;
  logic                            final_blk;
  logic                            last;

  assign cfg_ready = 1'b1;

  mdbp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_byte_valid(in_tuser[0]),
    .in_eom       (in_tlast),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mdbp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_bit  (cfg_data[0]),
    .cmd      (cmd),
    .sts      (sts),
    .word     (word),
    .word_idx (word_idx),
    .final_blk(final_blk),
    .last     (last)
  );

  assign out_tdata = {(mdbp_pkg::OUT_TDATA_W - mdbp_pkg::WORD_W - mdbp_pkg::WORD_IDX_W)'(0),
                      word_idx, word};
  assign out_tuser = final_blk;
  assign out_tlast = last;

endmodule

`default_nettype wire

// ----- tb/tb_md_block_padder.sv -----
`timescale 1ns / 1ps
// tb_md_block_padder: self-checking testbench for the 64-byte block padder
// predicts padded block words from the byte stream; needs mdbp_pkg and md_block_padder

module tb_md_block_padder;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 100;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [mdbp_pkg::WORD_W-1:0]     word;
    logic [mdbp_pkg::WORD_IDX_W-1:0] idx;
    logic                            final_blk;
    logic                            run_end;
  } block_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic [0:0]  in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = 1'b0;

  // padder state as predicted
  logic [mdbp_pkg::DATA_W-1:0]  blk_bytes [mdbp_pkg::BLOCK_BYTES];
  logic [6:0]                   fill_cnt       = '0;
  logic [mdbp_pkg::COUNT_W-1:0] msg_bytes      = '0;
  logic                         len_big_endian = 1'b0;
  block_word_t                  pending_words [$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int messages_sent = 0;
  int words_seen    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  md_block_padder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic queue_block(input logic fin);
    block_word_t w;
    for (int i = 0; i < mdbp_pkg::WORDS_PER_BLOCK; i++) begin
      w.word      = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
      w.idx       = mdbp_pkg::WORD_IDX_W'(i);
      w.final_blk = fin;
      w.run_end   = 1'b0;
      pending_words.push_back(w);
    end
  endtask

  task automatic pad_predict(input logic [7:0] data, input logic present, input logic ends);
    int          n_prior;
    logic [63:0] bit_len;
    block_word_t tail;
    n_prior  = pending_words.size();
    fill_cnt = {1'b0, fill_cnt[5:0]};
    if (present) begin
      blk_bytes[fill_cnt[5:0]] = data;
      fill_cnt  = fill_cnt + 7'd1;
      msg_bytes = msg_bytes + 1'b1;
      if (fill_cnt >= 7'(mdbp_pkg::BLOCK_BYTES)) begin
        queue_block(1'b0);
        fill_cnt = '0;
      end
    end
    if (ends) begin
      bit_len = {msg_bytes, 3'b000};
      blk_bytes[fill_cnt[5:0]] = mdbp_pkg::PAD_MARK;
      fill_cnt = fill_cnt + 7'd1;
      // no room left for the length: flush this block first
      if (fill_cnt > 7'(mdbp_pkg::LEN_AT)) begin
        for (int k = fill_cnt; k < mdbp_pkg::BLOCK_BYTES; k++) blk_bytes[k] = '0;
        queue_block(1'b0);
        fill_cnt = '0;
      end
      for (int k = fill_cnt; k < mdbp_pkg::LEN_AT; k++) blk_bytes[k] = '0;
      for (int k = 0; k < 8; k++)
        blk_bytes[mdbp_pkg::LEN_AT+k] = len_big_endian ? bit_len[(56-8*k) +: 8] :
                                                         bit_len[8*k +: 8];
      queue_block(1'b1);
      fill_cnt  = '0;
      msg_bytes = '0;
    end
    if (pending_words.size() > n_prior) begin
      tail = pending_words.pop_back();
      tail.run_end = 1'b1;
      pending_words.push_back(tail);
    end
  endtask

  task automatic send_item(input logic [7:0] data, input logic present, input logic ends);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= ends;
    do @(posedge clk); while (!in_tready);
    pad_predict(data, present, ends);
    if (present || ends) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_length_order(input logic big);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= big;
    do @(posedge clk); while (!cfg_ready);
    len_big_endian = big;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int len, input logic end_on_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    messages_sent++;
  endtask

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_length_order(1'b0);
    send_item(8'hFF, 1'b0, 1'b0);  // idle transfer, no output
    send_item(8'h00, 1'b0, 1'b1);  // empty message
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    set_length_order(1'b1);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h3C, 1'b1, 1'b0);
    send_item(8'hC3, 1'b1, 1'b1);
    messages_sent += 5;
  endtask

  task automatic test_block_boundaries();
    in_idle_pct   = 9;
    out_stall_pct = 9;
    send_message(56, 1'b1);  // pad byte at 56, extra block
    send_message(64, 1'b1);  // full block and length block from one transfer
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input logic big,
                                     input int n_items);
    int start;
    int pick;
    int len;
    in_idle_pct   = idle;
    out_stall_pct = stall;
    set_length_order(big);
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        len = $urandom_range(9, 0);
        send_message(len, 1'($urandom_range(1)));
        if ($urandom_range(99) < 20) wait_drained();
      end else if (pick < 85) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end else begin
        send_item(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  always @(posedge clk) begin
    block_word_t got;
    block_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[35:32], out_tuser[0], out_tlast};
      words_seen++;
      if (pending_words.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected word %h idx %0d final %b last %b",
                   got.word, got.idx, got.final_blk, got.run_end);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got != want) begin
          if (mismatches < MAX_REPORTS)
            $display("word mismatch: expected %h idx %0d final %b last %b, got %h idx %0d final %b last %b",
                     want.word, want.idx, want.final_blk, want.run_end,
                     got.word, got.idx, got.final_blk, got.run_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
               QUIET_LIMIT, pending_words.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_block_boundaries();
    test_random_traffic(0, 0, 1'b0, 6);
    test_random_traffic(73, 0, 1'b1, 6);
    test_random_traffic(0, 73, 1'b0, 6);
    test_random_traffic(9, 9, 1'b1, 6);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("%0d expected words never arrived", pending_words.size());
      mismatches += pending_words.size();
    end
    $display("sent %0d message transfers in %0d messages, checked %0d block words, %0d bad",
             items_sent, messages_sent, words_seen, mismatches);
    $display("both length orders, pad byte at offset 56 and a full-block end, four idle mixes");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- md_block_padder.f -----
+incdir+hw/rtl
hw/rtl/mdbp_pkg.sv
hw/rtl/mdbp_ram.sv
hw/rtl/mdbp_dp.sv
hw/rtl/mdbp_ctrl.sv
hw/rtl/md_block_padder.sv
tb/tb_md_block_padder.sv
